// File: design/aar3d_pkg.sv
// Package: shared widths, CORDIC constants and arctangent table.
package aar3d_pkg;

  localparam int VEC_W   = 32;
  localparam int AXIS_W  = 16;
  localparam int ANG_W   = 16;
  localparam int ATAN_N  = 30;
  localparam int CW      = 34;   // CORDIC datapath width, Q2.30 plus guard bits
  localparam int MW      = 34;   // matrix element width, Q26 plus integer bits

  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sh026DD3B6A;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sh040000000;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [MW-1:0] mw_t;

  // Input item payload.
  typedef struct packed {
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [ANG_W-1:0]  turn_angle;
  } in_item_t;

  // Result item payload.
  typedef struct packed {
    logic signed [VEC_W-1:0] rot_x;
    logic signed [VEC_W-1:0] rot_y;
    logic signed [VEC_W-1:0] rot_z;
  } out_item_t;

  // atan(2^-i) in Q2.30, truncated.
  function automatic cw_t atan_q30(input logic [4:0] i);
    cw_t r;
    r = '0;
    unique case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      5'd24: r = 34'sh00000003F;
      5'd25: r = 34'sh00000001F;
      5'd26: r = 34'sh00000000F;
      5'd27: r = 34'sh000000008;
      5'd28: r = 34'sh000000004;
      5'd29: r = 34'sh000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/aar3d_if.sv
// Interface: valid/ready channel carrying one payload item.
interface aar3d_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/aar3d_cordic.sv
// Pipelined CORDIC rotation: one stage per iteration, stalls with the enable.
module aar3d_cordic #(
  parameter int STAGES = 16,
  parameter int PW     = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  aar3d_pkg::cw_t          z_in,
  input  logic                    neg_in,
  input  logic [PW-1:0]           pass_in,
  output aar3d_pkg::cw_t          sin_out,
  output aar3d_pkg::cw_t          cos_out,
  output logic [PW-1:0]           pass_out
);
  localparam int N = (STAGES < aar3d_pkg::ATAN_N) ? STAGES : aar3d_pkg::ATAN_N;

  aar3d_pkg::cw_t  x_r [N+1];
  aar3d_pkg::cw_t  y_r [N+1];
  aar3d_pkg::cw_t  z_r [N+1];
  logic            neg_r [N+1];
  logic [PW-1:0]   pass_r [N+1];

  assign x_r[0]    = aar3d_pkg::GAIN_Q30;
  assign y_r[0]    = '0;
  assign z_r[0]    = z_in;
  assign neg_r[0]  = neg_in;
  assign pass_r[0] = pass_in;

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_stage
    aar3d_pkg::cw_t dx, dy, at;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign at = aar3d_pkg::atan_q30(5'(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][aar3d_pkg::CW-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + at;
        end
        neg_r[i+1]  <= neg_r[i];
        pass_r[i+1] <= pass_r[i];
      end
    end
  end

  assign cos_out  = neg_r[N] ? -x_r[N] : x_r[N];
  assign sin_out  = neg_r[N] ? -y_r[N] : y_r[N];
  assign pass_out = pass_r[N];
endmodule

// File: design/axis_angle_rotation_3d.sv
// Top level: Rodrigues rotation of a Q16.16 vector about a Q1.14 axis.
// Pipeline: stage 0 angle reduction, the CORDIC stages, stages A to E and the output register.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall freezes every stage.
// Reset (rst_n, synchronous, active low) clears all valid bits; payload
// registers are not reset.
module axis_angle_rotation_3d #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  aar3d_if.sink   in_ch,
  aar3d_if.source out_ch
);
  localparam int N   = (CORDIC_STAGES < aar3d_pkg::ATAN_N) ?
                       CORDIC_STAGES : aar3d_pkg::ATAN_N;
  localparam int LAT = N + 6;
  localparam int PW  = $bits(aar3d_pkg::in_item_t) - aar3d_pkg::ANG_W;

  typedef logic signed [aar3d_pkg::MW-1:0] m_t;

  logic           en;
  logic [LAT:0]   vld_r;

  // Whole pipeline moves when the final register can accept.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Valid shift line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld_r[LAT];

  // Stage 0: angle to Q2.30 and quarter-turn reduction.
  aar3d_pkg::cw_t z0_r;
  logic           neg0_r;
  logic [PW-1:0]  p0_r;
  aar3d_pkg::cw_t zin;
  assign zin = aar3d_pkg::CW'(in_ch.data.turn_angle) <<< 17;
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= in_ch.data[$bits(aar3d_pkg::in_item_t)-1:aar3d_pkg::ANG_W];
      if (zin > aar3d_pkg::HALF_PI_Q30) begin
        z0_r <= zin - aar3d_pkg::PI_Q30; neg0_r <= 1'b1;
      end else if (zin < -aar3d_pkg::HALF_PI_Q30) begin
        z0_r <= zin + aar3d_pkg::PI_Q30; neg0_r <= 1'b1;
      end else begin
        z0_r <= zin; neg0_r <= 1'b0;
      end
    end
  end

  aar3d_pkg::cw_t s_w, c_w;
  logic [PW-1:0]  pc_w;
  aar3d_cordic #(.STAGES(CORDIC_STAGES), .PW(PW)) u_cordic (
    .clk(clk), .en(en), .z_in(z0_r), .neg_in(neg0_r), .pass_in(p0_r),
    .sin_out(s_w), .cos_out(c_w), .pass_out(pc_w)
  );

  logic signed [31:0] vx, vy, vz;
  logic signed [15:0] ax, ay, az;
  assign {vx, vy, vz, ax, ay, az} = pc_w;

  // Stage A: axis products, 1-c, sine terms, rounded cosine.
  logic signed [31:0] aa_r [6];   // xx yy zz xy xz yz, Q4.28
  logic signed [47:0] as_r [3];   // a_k*s, Q44
  logic signed [34:0] omc_r;
  m_t                 c26_r;
  logic signed [31:0] va_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      aa_r[0] <= ax * ax; aa_r[1] <= ay * ay; aa_r[2] <= az * az;
      aa_r[3] <= ax * ay; aa_r[4] <= ax * az; aa_r[5] <= ay * az;
      as_r[0] <= ax * s_w; as_r[1] <= ay * s_w; as_r[2] <= az * s_w;
      omc_r   <= 35'(aar3d_pkg::ONE_Q30) - 35'(c_w);
      c26_r   <= m_t'((c_w + 34'sd8) >>> 4);
      va_r[0] <= vx; va_r[1] <= vy; va_r[2] <= vz;
    end
  end

  // Stage B: a_i*a_j*(1-c) rounded to Q26; sine terms to Q26.
  logic signed [66:0] t_w [6];
  m_t                 sym_r [6];
  m_t                 sk_r [3];
  m_t                 c26b_r;
  logic signed [31:0] vb_r [3];
  for (genvar k = 0; k < 6; k++) begin : g_sym
    assign t_w[k] = aa_r[k] * omc_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++)
        sym_r[k] <= m_t'((t_w[k] + (67'sd1 <<< 31)) >>> 32);
      for (int k = 0; k < 3; k++) begin
        sk_r[k] <= m_t'((as_r[k] + 48'sd131072) >>> 18);
        vb_r[k] <= va_r[k];
      end
      c26b_r <= c26_r;
    end
  end

  // Stage C: assemble the matrix.
  m_t                 m_r [9];
  logic signed [31:0] vc_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= sym_r[0] + c26b_r;
      m_r[1] <= sym_r[3] - sk_r[2];
      m_r[2] <= sym_r[4] + sk_r[1];
      m_r[3] <= sym_r[3] + sk_r[2];
      m_r[4] <= sym_r[1] + c26b_r;
      m_r[5] <= sym_r[5] - sk_r[0];
      m_r[6] <= sym_r[4] - sk_r[1];
      m_r[7] <= sym_r[5] + sk_r[0];
      m_r[8] <= sym_r[2] + c26b_r;
      for (int k = 0; k < 3; k++) vc_r[k] <= vb_r[k];
    end
  end

  // Stage D: nine vector-by-matrix products.
  logic signed [65:0] p_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++)
        p_r[k] <= vc_r[k % 3] * m_r[k];
    end
  end

  // Stage E: row sums with rounding.
  logic signed [67:0] sum_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++)
        sum_r[k] <= ((68'(p_r[3*k]) + 68'(p_r[3*k+1]) + 68'(p_r[3*k+2])
                     + (68'sd1 <<< 25)) >>> 26);
    end
  end

  // Output register: saturation to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  aar3d_pkg::out_item_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.rot_x <= sat32(sum_r[0]);
      out_r.rot_y <= sat32(sum_r[1]);
      out_r.rot_z <= sat32(sum_r[2]);
    end
  end
  assign out_ch.data = out_r;
endmodule

// File: dv/axis_angle_rotation_3d_tb.sv
// Testbench for axis_angle_rotation_3d: random and directed rotations checked against a predictor.
module axis_angle_rotation_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES      = 16;
  localparam int RAND_ITEMS  = 1100;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LIMIT = 5000;

  localparam longint ROT_GAIN = 64'h26DD3B6A;
  localparam longint ROT_PI   = 64'd3373259426;
  localparam longint ROT_HPI  = 64'd1686629713;
  localparam longint ARCTAN [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

  logic clk;
  logic rst_n;

  aar3d_if #(.T(aar3d_pkg::in_item_t))  in_ch ();
  aar3d_if #(.T(aar3d_pkg::out_item_t)) out_ch ();

  axis_angle_rotation_3d #(.CORDIC_STAGES(STAGES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aar3d_pkg::in_item_t  pending_vecs[$];
  aar3d_pkg::out_item_t expected_rots[$];
  int        n_sent;
  int        n_total;
  int        errors;
  int        idle_cycles;

  // Rodrigues rotation with CORDIC sine/cosine, bit exact
  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  function automatic aar3d_pkg::out_item_t rotate_vec(aar3d_pkg::in_item_t it);
    longint v[3], a[3], m[3][3];
    longint x, y, z, dx, dy, s, c, omc, c26, sx, sy, sz, acc;
    bit     flip;
    aar3d_pkg::out_item_t r;
    v[0] = longint'(it.vec_x); v[1] = longint'(it.vec_y); v[2] = longint'(it.vec_z);
    a[0] = longint'(it.axis_x); a[1] = longint'(it.axis_y); a[2] = longint'(it.axis_z);
    z = longint'(it.turn_angle) * 131072;
    x = ROT_GAIN;
    y = 0;
    flip = 0;
    // fold angles past a quarter turn
    if (z > ROT_HPI) begin
      z -= ROT_PI; flip = 1;
    end else if (z < -ROT_HPI) begin
      z += ROT_PI; flip = 1;
    end
    for (int i = 0; i < STAGES && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = (longint'(1) <<< 30) - c;
    c26 = rnd_shift(c, 4);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = rnd_shift(a[i] * a[j] * omc, 32);
    for (int i = 0; i < 3; i++) m[i][i] += c26;
    sx = rnd_shift(a[0] * s, 18);
    sy = rnd_shift(a[1] * s, 18);
    sz = rnd_shift(a[2] * s, 18);
    m[0][1] -= sz; m[1][0] += sz;
    m[0][2] += sy; m[2][0] -= sy;
    m[1][2] -= sx; m[2][1] += sx;
    acc = v[0] * m[0][0] + v[1] * m[0][1] + v[2] * m[0][2];
    r.rot_x = sat32(rnd_shift(acc, 26));
    acc = v[0] * m[1][0] + v[1] * m[1][1] + v[2] * m[1][2];
    r.rot_y = sat32(rnd_shift(acc, 26));
    acc = v[0] * m[2][0] + v[1] * m[2][1] + v[2] * m[2][2];
    r.rot_z = sat32(rnd_shift(acc, 26));
    return r;
  endfunction

  function automatic aar3d_pkg::in_item_t mk_item(int vx, int vy, int vz, shortint ax,
                                                  shortint ay, shortint az, shortint ang);
    aar3d_pkg::in_item_t it;
    it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
    it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
    it.turn_angle = ang;
    return it;
  endfunction

  function automatic int rand_vec_comp();
    int sh;
    sh = $urandom_range(0, 31);
    return $signed($urandom) >>> sh;
  endfunction

  function automatic shortint rand_axis_comp();
    return shortint'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  function automatic aar3d_pkg::in_item_t rand_item();
    aar3d_pkg::in_item_t it;
    real      fx, fy, fz, len;
    it = mk_item(rand_vec_comp(), rand_vec_comp(), rand_vec_comp(),
                 rand_axis_comp(), rand_axis_comp(), rand_axis_comp(), 0);
    // mostly unit axes; the rest arbitrary in range
    if ($urandom_range(0, 99) < 70) begin
      fx = real'(it.axis_x); fy = real'(it.axis_y); fz = real'(it.axis_z);
      len = $sqrt(fx * fx + fy * fy + fz * fz);
      if (len > 1.0) begin
        it.axis_x = shortint'($rtoi(fx * 16384.0 / len));
        it.axis_y = shortint'($rtoi(fy * 16384.0 / len));
        it.axis_z = shortint'($rtoi(fz * 16384.0 / len));
      end
    end
    if ($urandom_range(0, 99) < 85)
      it.turn_angle = shortint'($urandom_range(0, 51472)) - 16'sd25736;
    else
      it.turn_angle = shortint'($urandom);
    return it;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // idle odds per phase: sender/receiver idle 17/70, then 70/17, then none
  function automatic int send_idle_pct();
    if (n_sent < n_total / 3) return 17;
    if (n_sent < 2 * n_total / 3) return 70;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_sent < n_total / 3) return 70;
    if (n_sent < 2 * n_total / 3) return 17;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_vecs.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
  end

  // monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    aar3d_pkg::out_item_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rots.push_back(rotate_vec(in_ch.data));
        n_sent <= n_sent + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rots.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_ch.data);
          errors = errors + 1;
        end else begin
          want = expected_rots.pop_front();
          if (want.rot_x !== out_ch.data.rot_x) begin
            $display("%0t: rot_x expected %0d actual %0d", $realtime, want.rot_x,
                     out_ch.data.rot_x);
            errors = errors + 1;
          end
          if (want.rot_y !== out_ch.data.rot_y) begin
            $display("%0t: rot_y expected %0d actual %0d", $realtime, want.rot_y,
                     out_ch.data.rot_y);
            errors = errors + 1;
          end
          if (want.rot_z !== out_ch.data.rot_z) begin
            $display("%0t: rot_z expected %0d actual %0d", $realtime, want.rot_z,
                     out_ch.data.rot_z);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no accept on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_sent      = 0;
    errors      = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;

    // directed: zero angle, quarter-turn edges, pi, out-of-range angles, axis and vector extremes
    pending_vecs.push_back(mk_item(32'h00010000, 0, 0, 0, 0, 16384, 0));
    pending_vecs.push_back(mk_item(32'h00010000, 0, 0, 0, 0, 16384, 12868));
    pending_vecs.push_back(mk_item(32'h00010000, 0, 0, 0, 0, 16384, 12869));
    pending_vecs.push_back(mk_item(32'h00010000, 0, 0, 0, 0, 16384, -12868));
    pending_vecs.push_back(mk_item(32'h00010000, 0, 0, 0, 0, 16384, -12869));
    pending_vecs.push_back(mk_item(0, 32'h00010000, 0, 16384, 0, 0, 25736));
    pending_vecs.push_back(mk_item(0, 32'h00010000, 0, -16384, 0, 0, -25736));
    pending_vecs.push_back(mk_item(0, 0, 32'h00010000, 0, 16384, 0, 32767));
    pending_vecs.push_back(mk_item(0, 0, 32'h00010000, 0, -16384, 0, -32768));
    pending_vecs.push_back(mk_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                   16384, 16384, 16384, 8000));
    pending_vecs.push_back(mk_item(32'h80000000, 32'h80000000, 32'h80000000,
                                   -16384, -16384, -16384, -8000));
    pending_vecs.push_back(mk_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                   16384, -16384, 0, 25736));
    pending_vecs.push_back(mk_item(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 12000));
    pending_vecs.push_back(mk_item(32'hFFFFFFFF, 1, -1, 9459, 9459, 9459, 20000));
    pending_vecs.push_back(mk_item(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F,
                                   9459, -9459, 9459, -32768));
    pending_vecs.push_back(mk_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                   16384, 16384, -16384, 32767));
    pending_vecs.push_back(mk_item(0, 0, 0, 16384, 0, 0, 1000));
    pending_vecs.push_back(mk_item(32'h00010000, 32'h00020000, 32'h00030000,
                                   11585, 11585, 0, 1));
    pending_vecs.push_back(mk_item(32'h00010000, 32'h00020000, 32'h00030000,
                                   11585, 0, -11585, -1));
    for (int i = 0; i < RAND_ITEMS; i++) pending_vecs.push_back(rand_item());
    n_total = pending_vecs.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_vecs.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (expected_rots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && expected_rots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
